// ===== rtl/pca_pkg.sv =====
// Package for the proximity cluster assigner.
// Holds shared widths, the range reset value and the sequencer state type.
// No dependencies.
package pca_pkg;

  localparam int unsigned MAX_PIECES_DEF = 32;
  localparam int unsigned COORD_BITS_DEF = 12;

  localparam int unsigned RANGE_W = 25;
  localparam int unsigned ID_OUT_W = 5;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 25'd10000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } pca_state_e;

endpackage

// ===== rtl/proximity_cluster_assigner.sv =====
// Top level of the proximity cluster assigner.
// Depends on pca_pkg and on pca_ram for the point store.
//
// Usage: a request on the input channel carries frame_start, piece_present and a
// position. It is taken when in_valid_i is high and in_stall_o is low. A request
// with piece_present low gives no result; its frame_start still empties the store.
// Each present piece gives one result on the output channel, taken when
// out_valid_o is high and out_stall_i is low.
// The stored points of the frame sit in one RAM with a registered read. A piece
// streams over the N points stored so far, one read per cycle, through a
// squaring stage and a compare stage, and is then written back into the next
// slot. With an empty store no reads are issued before the result; a piece that
// finds the store full goes straight to its result, is not stored and gives a
// result with store_full_o set.
// The input is stalled while a piece is in work, but a new request is taken while
// the previous result still waits on a stalled output. If the output is still
// occupied when a piece finishes, the piece waits until the result register frees.
// range_squared_we_i loads the range register; the user must write it only while
// the block is idle, as the block does not enforce this. Reset empties the store,
// clears both counts, sets the range to 10000 and drops any pending result.
module proximity_cluster_assigner
  import pca_pkg::*;
#(
  parameter int unsigned MAX_PIECES = MAX_PIECES_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  range_squared_we_i,
  input  logic [RANGE_W-1:0]    range_squared_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  frame_start_i,
  input  logic                  piece_present_i,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ID_OUT_W-1:0]   cluster_id_o,
  output logic                  new_cluster_o,
  output logic [ID_OUT_W-1:0]   entry_index_o,
  output logic                  store_full_o
);

  localparam int unsigned IdW = $clog2(MAX_PIECES);
  localparam int unsigned CntW = $clog2(MAX_PIECES + 1);
  localparam int unsigned SqW = 2 * COORD_BITS;
  localparam int unsigned CmpW = (SqW + 1 > RANGE_W) ? SqW + 1 : RANGE_W;
  localparam int unsigned MemW = 2 * COORD_BITS + IdW;

  pca_state_e state_q, state_d;

  logic [RANGE_W-1:0]    range_q;
  logic [CntW-1:0]       entry_cnt_q;
  logic [CntW-1:0]       cluster_cnt_q;
  logic [CntW-1:0]       rd_idx_q;
  logic                  p1_vld_q, p2_vld_q;
  logic                  found_q;
  logic                  full_q;
  logic                  out_vld_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [SqW-1:0]        sq_x_q, sq_y_q;
  logic [IdW-1:0]        cl_q;
  logic [IdW-1:0]        best_q;
  logic [ID_OUT_W-1:0]   cluster_id_q, entry_index_q;
  logic                  new_cluster_q, store_full_q;

  logic                  accept, issue, out_free, done_scan, full_now, hit, ram_we;
  logic [MemW-1:0]       rdata, wdata;
  logic [COORD_BITS-1:0] rd_x, rd_y, dx, dy;
  logic [IdW-1:0]        rd_cl, new_id;
  logic [CmpW-1:0]       dist_sum;

  assign rd_x  = rdata[MemW-1 -: COORD_BITS];
  assign rd_y  = rdata[IdW +: COORD_BITS];
  assign rd_cl = rdata[IdW-1:0];
  assign dx    = (x_q >= rd_x) ? x_q - rd_x : rd_x - x_q;
  assign dy    = (y_q >= rd_y) ? y_q - rd_y : rd_y - y_q;

  assign dist_sum = CmpW'(sq_x_q) + CmpW'(sq_y_q);
  assign hit      = dist_sum < CmpW'(range_q);

  assign out_free  = !out_vld_q || !out_stall_i;
  assign done_scan = (rd_idx_q == entry_cnt_q) && !p1_vld_q && !p2_vld_q;
  assign full_now  = !frame_start_i && (entry_cnt_q == CntW'(MAX_PIECES));
  assign new_id    = found_q ? best_q : cluster_cnt_q[IdW-1:0];
  assign wdata     = {x_q, y_q, new_id};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && piece_present_i) begin
          state_d = full_now ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (done_scan) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    accept     = in_valid_i && (state_q == S_IDLE);
    issue      = (state_q == S_SCAN) && (rd_idx_q != entry_cnt_q);
    ram_we     = (state_q == S_DONE) && out_free && !full_q;
  end

  pca_ram #(
    .WIDTH(MemW),
    .DEPTH(MAX_PIECES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(entry_cnt_q[IdW-1:0]),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q[IdW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      range_q       <= RANGE_RESET;
      entry_cnt_q   <= '0;
      cluster_cnt_q <= '0;
      rd_idx_q      <= '0;
      p1_vld_q      <= 1'b0;
      p2_vld_q      <= 1'b0;
      found_q       <= 1'b0;
      full_q        <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q;
      if (range_squared_we_i) begin
        range_q <= range_squared_i;
      end
      if (accept) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
        full_q   <= full_now;
        if (frame_start_i) begin
          entry_cnt_q   <= '0;
          cluster_cnt_q <= '0;
        end
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      if (p2_vld_q && hit) begin
        found_q <= 1'b1;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_vld_q <= 1'b1;
        if (!full_q) begin
          entry_cnt_q <= entry_cnt_q + CntW'(1);
          if (!found_q) begin
            cluster_cnt_q <= cluster_cnt_q + CntW'(1);
          end
        end
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
    end
    if (p1_vld_q) begin
      sq_x_q <= SqW'(dx) * SqW'(dx);
      sq_y_q <= SqW'(dy) * SqW'(dy);
      cl_q   <= rd_cl;
    end
    if (p2_vld_q && hit && (!found_q || (cl_q < best_q))) begin
      best_q <= cl_q;
    end
    if ((state_q == S_DONE) && out_free) begin
      store_full_q <= full_q;
      if (full_q) begin
        cluster_id_q  <= '0;
        new_cluster_q <= 1'b0;
        entry_index_q <= '0;
      end else begin
        cluster_id_q  <= ID_OUT_W'(new_id);
        new_cluster_q <= !found_q;
        entry_index_q <= ID_OUT_W'(entry_cnt_q);
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign cluster_id_o  = cluster_id_q;
  assign new_cluster_o = new_cluster_q;
  assign entry_index_o = entry_index_q;
  assign store_full_o  = store_full_q;

endmodule

// ===== rtl/pca_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
